// ----- hw/rtl/dwr_pkg.sv -----
// Shared types and codes for the reversible double-ended queue.
// Used by dwr_ctrl, dwr_dp and deque_with_reverse; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dwr_pkg;

   localparam int unsigned DEPTH_DEF = 1024;

   // Request codes.
   localparam logic [2:0] OP_POP_BACK   = 3'd0;
   localparam logic [2:0] OP_POP_FRONT  = 3'd1;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd3;
   localparam logic [2:0] OP_TOGGLE     = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_POPPED = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] push_value;
   } dwr_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] pop_value;
   } dwr_rsp_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic exec;
   } dwr_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } dwr_state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/dwr_ctrl.sv -----
// Controller for the reversible deque: accepts one item, then holds its result.
// Depends on dwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dwr_ctrl
   import dwr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output dwr_cmd_type      cmd
);

   dwr_state_type state_ff;
   dwr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/dwr_dp.sv -----
// Datapath for the reversible deque: ring store, pointers and result register.
// Depends on dwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dwr_dp
   import dwr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dwr_cmd_type cmd,
   input  wire dwr_req_type req_data,
   output dwr_rsp_type      rsp_data
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   logic [31:0]      mem [DEPTH];
   logic [31:0]      rd_data_ff;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rev_ff, rev_in;
   logic [1:0]       status_ff, status_in;
   logic             popped_ff;

   logic             is_pop, is_push, at_front, empty, full;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [IDX_W-1:0] front_dec, front_inc;
   logic [SUM_W-1:0] tail_sum, back_sum;
   logic [IDX_W-1:0] tail_slot, back_slot;

   always_comb begin
      is_pop  = (req_data.req_type == OP_POP_BACK) || (req_data.req_type == OP_POP_FRONT);
      is_push = (req_data.req_type == OP_PUSH_BACK) || (req_data.req_type == OP_PUSH_FRONT);
      // Reversal swaps the logical ends onto the physical ones.
      at_front = ((req_data.req_type == OP_POP_FRONT) ||
                  (req_data.req_type == OP_PUSH_FRONT)) ^ rev_ff;
      empty = (count_ff == '0);
      full  = (count_ff == CNT_W'(DEPTH));

      front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
      front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

      // Both sums stay below twice the depth, so one subtract wraps them.
      tail_sum = SUM_W'(front_ff) + SUM_W'(count_ff);
      back_sum = tail_sum - 1'b1;
      tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                              : IDX_W'(tail_sum);
      back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                              : IDX_W'(back_sum);

      front_in  = front_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = ST_DONE;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = at_front ? front_dec : tail_slot;
      rd_addr   = at_front ? front_ff : back_slot;

      if (cmd.exec) begin
         if (is_pop) begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in = ST_POPPED;
               rd_en     = 1'b1;
               count_in  = count_ff - 1'b1;
               if (at_front) begin
                  front_in = front_inc;
               end
            end
         end else if (is_push) begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (at_front) begin
                  front_in = front_dec;
               end
            end
         end else if (req_data.req_type == OP_TOGGLE) begin
            rev_in = ~rev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         popped_ff <= (status_in == ST_POPPED);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_data.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_data.status    = status_ff;
   assign rsp_data.pop_value = popped_ff ? signed'(rd_data_ff) : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/deque_with_reverse.sv -----
// Top level of the bounded double-ended queue with reverse mode.
// Depends on dwr_pkg, dwr_ctrl and dwr_dp.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// Requests arrive on req_valid/req_ready with req_data carrying the request
// code and a push value. Each request gives exactly one result on
// rsp_valid/rsp_ready, with a status code and the popped value (zero unless
// an item was popped).
// A request accepted at one clock edge has its result valid in the
// following cycle, since a pop reads the ring store through a registered
// read port. The controller holds one item at a time, so a new request is
// taken the cycle after the result is taken.
// When the receiver stalls, the result stays on rsp_data and req_ready stays
// low until it is taken.
// Reset clears the front pointer, the item count and the reverse flag; the
// queue comes up empty and not reversed. The ring store is not cleared; it
// is only read at entries that a push has written. No clearing pass is
// needed, so requests are taken from the first cycle after reset.
module deque_with_reverse
   import dwr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dwr_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output dwr_rsp_type      rsp_data
);

   dwr_cmd_type cmd;

   dwr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dwr_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   // An accepted item always has its result presented in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after an accepted item");

   // Only one item is in flight.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   // Only a successful pop carries a value.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_POPPED) |-> rsp_data.pop_value == '0)
      else $error("nonzero value without a pop");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/dwr_deque_check.sv -----
// Checker for the reversible double-ended queue: watches both channels, keeps its own
// copy of the ring store, pointers and reverse flag, and compares every result in order.
// Depends on dwr_pkg for the payload types and the request and status codes.
`timescale 1ns / 1ps
module dwr_deque_check
   import dwr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire dwr_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dwr_rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               level
);

   logic [31:0]  slot_mem [DEPTH];
   int unsigned  head_idx = 0;
   int unsigned  held = 0;
   bit           flipped = 1'b0;
   int           errs = 0;
   dwr_rsp_type  rsp_due_q [$];

   // Applies one request to the shadow queue and returns the result it must give.
   function automatic dwr_rsp_type deque_next_rsp(dwr_req_type r);
      dwr_rsp_type o;
      bit          at_head;
      o = '{status: ST_DONE, pop_value: '0};
      case (r.req_type)
         OP_POP_BACK, OP_POP_FRONT: begin
            // While reversed, the logical front is the physical back.
            at_head = (r.req_type == OP_POP_FRONT) ? !flipped : flipped;
            if (held == 0) begin
               o.status = ST_EMPTY;
            end else begin
               if (at_head) begin
                  o.pop_value = slot_mem[head_idx];
                  head_idx = (head_idx + 1) % DEPTH;
               end else begin
                  o.pop_value = slot_mem[(head_idx + held - 1) % DEPTH];
               end
               held--;
               o.status = ST_POPPED;
            end
         end
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            at_head = (r.req_type == OP_PUSH_FRONT) ? !flipped : flipped;
            if (held >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               if (at_head) begin
                  head_idx = (head_idx + DEPTH - 1) % DEPTH;
                  slot_mem[head_idx] = r.push_value;
               end else begin
                  slot_mem[(head_idx + held) % DEPTH] = r.push_value;
               end
               held++;
            end
         end
         OP_TOGGLE: begin
            flipped = !flipped;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : watch
      dwr_rsp_type want;
      if (reset) begin
         head_idx = 0;
         held = 0;
         flipped = 1'b0;
         rsp_due_q.delete();
      end else begin
         // A result always trails its request, so it is checked before a new one is queued.
         if (rsp_valid && rsp_ready) begin
            if (rsp_due_q.size() == 0) begin
               errs++;
               $display("%0t: unexpected result: expected none, actual status %0d value %0d",
                        $time, rsp_data.status, rsp_data.pop_value);
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  errs++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.pop_value !== want.pop_value) begin
                  errs++;
                  $display("%0t: pop_value mismatch: expected %0d, actual %0d",
                           $time, want.pop_value, rsp_data.pop_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            rsp_due_q.push_back(deque_next_rsp(req_data));
         end
      end
      fail_count <= errs;
      pending <= rsp_due_q.size();
      level <= held;
   end

endmodule

// ----- tb/sv/tb_deque_with_reverse.sv -----
// Top of the testbench for deque_with_reverse: clock, reset, request and result drivers.
// Depends on dwr_pkg, the block under test and the dwr_deque_check checker.
`timescale 1ns / 1ps
module tb_deque_with_reverse;
   import dwr_pkg::*;

   localparam int unsigned QDEPTH = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 300;

   // Request codes the block must ignore.
   localparam logic [2:0] OP_RSVD_5 = 3'd5;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dwr_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dwr_rsp_type rsp_data;

   int fail_count;
   int pending;
   int level;
   bit snd_gaps = 1'b0;
   bit rcv_gaps = 1'b0;
   int long_holds_asked = 0;

   deque_with_reverse #(.DEPTH(QDEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dwr_deque_check #(.DEPTH(QDEPTH)) deque_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending),
      .level      (level)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("deque_with_reverse test failed");
            $finish;
         end
      end
   end

   // Result side: a random hold before each item when rcv_gaps is set, or a long one when asked for.
   initial begin : receiver
      int hold;
      int long_holds_done;
      long_holds_done = 0;
      forever begin
         if (long_holds_done < long_holds_asked) begin
            hold = LONG_HOLD;
            long_holds_done++;
         end else if (rcv_gaps) begin
            hold = $urandom_range(0, 11);
         end else begin
            hold = 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_req(input logic [2:0] op, input logic [31:0] val);
      int gap;
      gap = snd_gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: op, push_value: val};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering items until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [2:0] pick_op(int unsigned push_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      if (r < 92) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      if (r < 97) return OP_TOGGLE;
      return 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 19))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: both empty errors, extreme values at both ends, reversal, ignored codes.
      send_req(OP_POP_BACK, 32'h0);
      send_req(OP_POP_FRONT, 32'hFFFF_FFFF);
      send_req(OP_PUSH_BACK, 32'h7FFF_FFFF);
      send_req(OP_PUSH_FRONT, 32'h8000_0000);
      send_req(OP_PUSH_BACK, 32'h0);
      send_req(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send_req(OP_POP_FRONT, 32'h0);
      send_req(OP_POP_BACK, 32'h0);
      send_req(OP_TOGGLE, 32'h0);
      send_req(OP_PUSH_BACK, 32'h5A5A_5A5A);
      send_req(OP_PUSH_FRONT, 32'hA5A5_A5A5);
      send_req(OP_POP_BACK, 32'hFFFF_FFFF);
      send_req(OP_POP_FRONT, 32'h0);
      send_req(OP_RSVD_5, 32'h1234_5678);
      send_req(OP_RSVD_6, 32'hFFFF_FFFF);
      send_req(OP_RSVD_7, 32'h8000_0000);
      send_req(OP_TOGGLE, 32'hFFFF_FFFF);
      send_req(OP_POP_FRONT, 32'h0);
      send_req(OP_POP_BACK, 32'h0);
      send_req(OP_POP_BACK, 32'h0);
      send_req(OP_POP_FRONT, 32'h0);
      wait_drained();

      // Near empty, with a long result stall partway through.
      snd_gaps = 1'b1;
      rcv_gaps = 1'b1;
      for (int i = 0; i < 200; i++) begin
         if (i == 60) long_holds_asked++;
         send_req(pick_op(45), pick_value());
      end
      wait_drained();

      // Fill to capacity from both ends so the ring wraps, then push into a full queue.
      snd_gaps = 1'b0;
      long_holds_asked++;
      while (level < int'(QDEPTH)) send_req(pick_op(92), pick_value());
      for (int i = 0; i < 8; i++) send_req(pick_op(100), pick_value());

      // Churn around the full mark.
      snd_gaps = 1'b1;
      for (int i = 0; i < 150; i++) send_req(pick_op(50), pick_value());
      wait_drained();

      // A stretch with no idling on either side, then idling again while draining.
      snd_gaps = 1'b0;
      rcv_gaps = 1'b0;
      for (int i = 0; i < 100; i++) send_req(pick_op(40), pick_value());
      snd_gaps = 1'b1;
      rcv_gaps = 1'b1;
      for (int i = 0; i < 100; i++) send_req(pick_op(30), pick_value());

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("deque_with_reverse test passed");
      end else begin
         $display("deque_with_reverse test failed");
      end
      $finish;
   end

endmodule
